### sv/hltb_pkg.sv
// Package for the Huffman lookup table builder.
// Holds field widths, the operation codes and the default table size.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hltb_pkg;

    localparam int COUNT_BYTES           = 16;
    localparam int COUNT_IDX_BITS        = $clog2(COUNT_BYTES);
    localparam int SYMBOL_BITS           = 8;
    localparam int LENGTH_BITS           = 5;
    localparam int INDEX_BITS            = 16;
    localparam int OP_BITS               = 2;
    localparam int ENTRY_BITS            = LENGTH_BITS + SYMBOL_BITS;
    localparam int DEFAULT_MAX_CODE_BITS = 16;

    typedef enum logic [OP_BITS-1:0] {
        OP_RESTART = 2'd0,
        OP_LOAD    = 2'd1,
        OP_READ    = 2'd2
    } t_op;

endpackage

`default_nettype wire

### sv/hltb_if.sv
// Channel interfaces for the Huffman lookup table builder.
// hltb_cmd_if carries command words in, hltb_rsp_if carries lookup words out.
// Depends on hltb_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface hltb_cmd_if import hltb_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [OP_BITS-1:0]     operation;
    logic [SYMBOL_BITS-1:0] spec_byte;
    logic [INDEX_BITS-1:0]  entry_index;

    modport source (output valid, output operation, output spec_byte,
                    output entry_index, input ready);
    modport sink   (input valid, input operation, input spec_byte,
                    input entry_index, output ready);
endinterface

interface hltb_rsp_if import hltb_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic                   entry_valid;
    logic [LENGTH_BITS-1:0] code_length;
    logic [SYMBOL_BITS-1:0] symbol;
    logic [LENGTH_BITS-1:0] longest_length;

    modport source (output valid, output entry_valid, output code_length,
                    output symbol, output longest_length, input ready);
    modport sink   (input valid, input entry_valid, input code_length,
                    input symbol, input longest_length, output ready);
endinterface

`default_nettype wire

### sv/huffman_lookup_table_builder.sv
// Top level of the Huffman lookup table builder: sequencer, count file,
// lookup memory and output register. Depends on hltb_pkg and hltb_if.
`timescale 1ns / 1ps
`default_nettype none

// The block takes one command word at a time and is not ready while it works
// on one. A restart, an ignored word and each of the first fifteen count loads
// are finished as they are taken. The sixteenth count load moves to a skip
// state that steps through the code lengths up to the shortest length that has
// symbols (one step for an empty table). A symbol load moves to a fill state
// that writes each table entry it covers (2^(max - len) writes through the
// single memory write port, fewer when the table fills up before the run
// ends), then to the skip state, which steps over the code lengths until it
// finds the next length that still has symbols. A read goes through the
// registered memory read and a read state, and a finished lookup word waits in
// the output register while the next command is already taken; a read that
// finds the output register still occupied waits until that word is taken. The
// table memory needs no clearing after reset: only entries below the fill point
// are ever read.
module huffman_lookup_table_builder
    import hltb_pkg::*;
#(
    parameter int MAX_CODE_BITS = DEFAULT_MAX_CODE_BITS
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    hltb_cmd_if.sink     i_cmd,
    hltb_rsp_if.source   o_rsp
);

    localparam int FP_BITS = MAX_CODE_BITS + 1;
    localparam int DEPTH   = 1 << MAX_CODE_BITS;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_FILL = 4'b0010,
        S_SKIP = 4'b0100,
        S_READ = 4'b1000
    } t_state;

    t_state r_state, n_state;

    logic [SYMBOL_BITS-1:0]   r_counts [COUNT_BYTES];
    logic [ENTRY_BITS-1:0]    r_mem [DEPTH];
    logic [ENTRY_BITS-1:0]    r_rd_q;

    logic [LENGTH_BITS-1:0]   r_bytes_loaded, n_bytes_loaded;
    logic [LENGTH_BITS-1:0]   r_max, n_max;
    logic [LENGTH_BITS-1:0]   r_max_seen, n_max_seen;
    logic [LENGTH_BITS-1:0]   r_cur, n_cur;
    logic [SYMBOL_BITS-1:0]   r_left, n_left;
    logic [FP_BITS-1:0]       r_fill_ptr, n_fill_ptr;
    logic [FP_BITS-1:0]       r_run, n_run;
    logic [SYMBOL_BITS-1:0]   r_sym, n_sym;
    logic [MAX_CODE_BITS-1:0] r_idx, n_idx;
    logic                     r_hit, n_hit;

    logic                     r_out_valid, n_out_valid;
    logic                     r_out_entry_valid, n_out_entry_valid;
    logic [LENGTH_BITS-1:0]   r_out_length, n_out_length;
    logic [SYMBOL_BITS-1:0]   r_out_symbol, n_out_symbol;
    logic [LENGTH_BITS-1:0]   r_out_longest, n_out_longest;

    logic                     w_accept;
    logic                     w_mem_we;
    logic                     w_cnt_we;
    logic [MAX_CODE_BITS-1:0] w_raddr;
    logic [FP_BITS-1:0]       w_limit;
    logic [SYMBOL_BITS-1:0]   w_count_next;

    assign i_cmd.ready = (r_state == S_IDLE);
    assign w_accept    = i_cmd.valid && i_cmd.ready;

    assign w_limit      = FP_BITS'(1) << r_max;
    assign w_count_next = (r_cur < LENGTH_BITS'(MAX_CODE_BITS))
                        ? r_counts[r_cur[COUNT_IDX_BITS-1:0]] : '0;
    assign w_raddr      = (r_state == S_READ)
                        ? r_idx : i_cmd.entry_index[MAX_CODE_BITS-1:0];

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.entry_valid    = r_out_entry_valid;
    assign o_rsp.code_length    = r_out_length;
    assign o_rsp.symbol         = r_out_symbol;
    assign o_rsp.longest_length = r_out_longest;

    always_comb begin
        n_state           = r_state;
        n_bytes_loaded    = r_bytes_loaded;
        n_max             = r_max;
        n_max_seen        = r_max_seen;
        n_cur             = r_cur;
        n_left            = r_left;
        n_fill_ptr        = r_fill_ptr;
        n_run             = r_run;
        n_sym             = r_sym;
        n_idx             = r_idx;
        n_hit             = r_hit;
        n_out_valid       = r_out_valid && !o_rsp.ready;
        n_out_entry_valid = r_out_entry_valid;
        n_out_length      = r_out_length;
        n_out_symbol      = r_out_symbol;
        n_out_longest     = r_out_longest;
        w_mem_we          = 1'b0;
        w_cnt_we          = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_cmd.operation)
                        OP_RESTART: begin
                            n_bytes_loaded = '0;
                            n_max          = '0;
                            n_max_seen     = '0;
                            n_cur          = LENGTH_BITS'(1);
                            n_left         = '0;
                            n_fill_ptr     = '0;
                        end
                        OP_LOAD: begin
                            if (r_bytes_loaded < LENGTH_BITS'(COUNT_BYTES)) begin
                                w_cnt_we       = 1'b1;
                                n_bytes_loaded = r_bytes_loaded + LENGTH_BITS'(1);
                                if ((i_cmd.spec_byte != '0) &&
                                    (r_bytes_loaded < LENGTH_BITS'(MAX_CODE_BITS))) begin
                                    n_max_seen = n_bytes_loaded;
                                end
                                if (n_bytes_loaded == LENGTH_BITS'(COUNT_BYTES)) begin
                                    // Stepping from length zero lands on length one first.
                                    n_max   = n_max_seen;
                                    n_cur   = '0;
                                    n_left  = '0;
                                    n_state = S_SKIP;
                                end
                            end else if ((r_cur <= r_max) && (r_cur != '0)) begin
                                n_sym   = i_cmd.spec_byte;
                                n_run   = FP_BITS'(1) << (r_max - r_cur);
                                n_state = S_FILL;
                            end
                        end
                        OP_READ: begin
                            n_idx   = i_cmd.entry_index[MAX_CODE_BITS-1:0];
                            n_hit   = ({1'b0, i_cmd.entry_index} <
                                       (INDEX_BITS + 1)'(r_fill_ptr));
                            n_state = S_READ;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_FILL: begin
                if ((r_fill_ptr < w_limit) && (r_run != FP_BITS'(1))) begin
                    w_mem_we   = 1'b1;
                    n_fill_ptr = r_fill_ptr + FP_BITS'(1);
                    n_run      = r_run - FP_BITS'(1);
                end else begin
                    if (r_fill_ptr < w_limit) begin
                        w_mem_we   = 1'b1;
                        n_fill_ptr = r_fill_ptr + FP_BITS'(1);
                    end
                    n_left  = r_left - SYMBOL_BITS'(1);
                    n_state = S_SKIP;
                end
            end
            S_SKIP: begin
                if ((r_left == '0) && (r_cur <= r_max)) begin
                    n_cur  = r_cur + LENGTH_BITS'(1);
                    n_left = w_count_next;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_READ: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid       = 1'b1;
                    n_out_entry_valid = r_hit;
                    n_out_length      = r_hit ? r_rd_q[ENTRY_BITS-1:SYMBOL_BITS] : '0;
                    n_out_symbol      = r_hit ? r_rd_q[SYMBOL_BITS-1:0] : '0;
                    n_out_longest     = r_max;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_bytes_loaded <= '0;
            r_max          <= '0;
            r_max_seen     <= '0;
            r_cur          <= LENGTH_BITS'(1);
            r_left         <= '0;
            r_fill_ptr     <= '0;
            r_run          <= FP_BITS'(1);
            r_out_valid    <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_bytes_loaded <= n_bytes_loaded;
            r_max          <= n_max;
            r_max_seen     <= n_max_seen;
            r_cur          <= n_cur;
            r_left         <= n_left;
            r_fill_ptr     <= n_fill_ptr;
            r_run          <= n_run;
            r_out_valid    <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sym             <= n_sym;
        r_idx             <= n_idx;
        r_hit             <= n_hit;
        r_out_entry_valid <= n_out_entry_valid;
        r_out_length      <= n_out_length;
        r_out_symbol      <= n_out_symbol;
        r_out_longest     <= n_out_longest;
        if (w_cnt_we) begin
            r_counts[r_bytes_loaded[COUNT_IDX_BITS-1:0]] <= i_cmd.spec_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[r_fill_ptr[MAX_CODE_BITS-1:0]] <= {r_cur, r_sym};
        end
        r_rd_q <= r_mem[w_raddr];
    end

    a_fill_within_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill_ptr <= w_limit)
        else $error("fill pointer passed the end of the table");

    a_run_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FILL) |-> (r_run != '0))
        else $error("fill run reached zero inside a fill");

    a_loaded_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bytes_loaded <= LENGTH_BITS'(COUNT_BYTES))
        else $error("count byte counter ran past sixteen");

    a_max_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_max <= LENGTH_BITS'(MAX_CODE_BITS)) && (r_max_seen <= LENGTH_BITS'(MAX_CODE_BITS)))
        else $error("longest length exceeds the table index width");

    a_miss_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_entry_valid) |-> ((r_out_length == '0) && (r_out_symbol == '0)))
        else $error("missed lookup carries a nonzero entry");

endmodule

`default_nettype wire

### test/hltb_lookup_check_pkg.sv
// Scoreboard for the Huffman lookup table builder test: a predictor of the
// table build and a queue of expected lookup words. Depends on hltb_pkg.
`timescale 1ns / 1ps

package hltb_lookup_check_pkg;

    import hltb_pkg::*;

    typedef struct packed {
        logic                   entry_valid;
        logic [LENGTH_BITS-1:0] code_length;
        logic [SYMBOL_BITS-1:0] symbol;
        logic [LENGTH_BITS-1:0] longest_length;
    } t_lookup;

    class lookup_table_scoreboard;
        bit [SYMBOL_BITS-1:0] length_counts [COUNT_BYTES];
        int unsigned          counts_taken;
        bit [LENGTH_BITS-1:0] longest;
        bit [LENGTH_BITS-1:0] fill_length;
        bit [SYMBOL_BITS-1:0] left_at_length;
        bit [INDEX_BITS:0]    fill_point;
        bit [ENTRY_BITS-1:0]  table_mem [1 << INDEX_BITS];
        t_lookup              pending_lookups [$];
        int unsigned          mismatches;

        function new();
            restart_load();
            mismatches = 0;
        endfunction

        function void restart_load();
            foreach (length_counts[i]) begin
                length_counts[i] = '0;
            end
            counts_taken   = 0;
            longest        = '0;
            fill_length    = LENGTH_BITS'(1);
            left_at_length = '0;
            fill_point     = '0;
        endfunction

        function bit [SYMBOL_BITS-1:0] count_of(bit [LENGTH_BITS-1:0] len);
            if (len < 1 || len > COUNT_BYTES) begin
                return '0;
            end
            return length_counts[len - 1];
        endfunction

        function void advance_length();
            while (left_at_length == 0 && fill_length <= longest) begin
                fill_length++;
                left_at_length = count_of(fill_length);
            end
        endfunction

        function void note_command(logic [OP_BITS-1:0] op, logic [SYMBOL_BITS-1:0] sb,
                                   logic [INDEX_BITS-1:0] ix);
            t_lookup            want;
            bit [INDEX_BITS:0]  limit;
            int unsigned        run;
            case (op)
                OP_RESTART: begin
                    restart_load();
                end
                OP_LOAD: begin
                    if (counts_taken < COUNT_BYTES) begin
                        length_counts[counts_taken] = sb;
                        counts_taken++;
                        if (counts_taken == COUNT_BYTES) begin
                            longest = '0;
                            for (int len = 1; len <= COUNT_BYTES; len++) begin
                                if (count_of(LENGTH_BITS'(len)) != 0) begin
                                    longest = LENGTH_BITS'(len);
                                end
                            end
                            fill_length    = LENGTH_BITS'(1);
                            left_at_length = count_of(LENGTH_BITS'(1));
                            advance_length();
                        end
                    end else if (fill_length >= 1 && fill_length <= longest) begin
                        limit = (INDEX_BITS + 1)'(1) << longest;
                        run   = 32'd1 << (longest - fill_length);
                        for (int unsigned k = 0; k < run && fill_point < limit; k++) begin
                            table_mem[fill_point[INDEX_BITS-1:0]] = {fill_length, sb};
                            fill_point++;
                        end
                        left_at_length--;
                        advance_length();
                    end
                end
                OP_READ: begin
                    want = '0;
                    if (ix < fill_point) begin
                        want.entry_valid = 1'b1;
                        want.code_length = table_mem[ix][ENTRY_BITS-1:SYMBOL_BITS];
                        want.symbol      = table_mem[ix][SYMBOL_BITS-1:0];
                    end
                    want.longest_length = longest;
                    pending_lookups.push_back(want);
                end
                default: begin
                end
            endcase
        endfunction

        function void check_lookup(t_lookup got);
            t_lookup want;
            if (pending_lookups.size() == 0) begin
                $error("lookup word arrived with no read outstanding");
                mismatches++;
                return;
            end
            want = pending_lookups.pop_front();
            if (got.entry_valid !== want.entry_valid) begin
                $error("entry_valid: expected %0d, got %0d", want.entry_valid, got.entry_valid);
                mismatches++;
            end
            if (got.code_length !== want.code_length) begin
                $error("code_length: expected %0d, got %0d", want.code_length, got.code_length);
                mismatches++;
            end
            if (got.symbol !== want.symbol) begin
                $error("symbol: expected 0x%02h, got 0x%02h", want.symbol, got.symbol);
                mismatches++;
            end
            if (got.longest_length !== want.longest_length) begin
                $error("longest_length: expected %0d, got %0d",
                       want.longest_length, got.longest_length);
                mismatches++;
            end
        endfunction
    endclass

endpackage

### test/huffman_lookup_table_builder_test.sv
// Testbench for huffman_lookup_table_builder: loads table specifications,
// reads entries back and checks each lookup word against the scoreboard.
// Depends on hltb_pkg, hltb_if and hltb_lookup_check_pkg.
`timescale 1ns / 1ps

module huffman_lookup_table_builder_test;

    import hltb_pkg::*;
    import hltb_lookup_check_pkg::*;

    localparam logic [OP_BITS-1:0] OP_UNUSED = 2'd3;
    localparam int IDLE_PERCENT  = 18;
    localparam int RANDOM_WORDS  = 1650;
    localparam int STALL_LIMIT   = 200000;
    localparam int TAIL_CYCLES   = 64;

    logic i_clk;
    logic i_rst_n;

    hltb_cmd_if cmd ();
    hltb_rsp_if rsp ();

    huffman_lookup_table_builder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_rsp   (rsp)
    );

    lookup_table_scoreboard lookup_sb;
    bit                     idle_on;
    int unsigned            words_sent;
    int unsigned            quiet_cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [SYMBOL_BITS-1:0] rand_byte();
        return SYMBOL_BITS'($urandom_range(0, 255));
    endfunction

    function automatic logic [INDEX_BITS-1:0] rand_index();
        return INDEX_BITS'($urandom_range(0, 16'hFFFF));
    endfunction

    task automatic send_word(input logic [OP_BITS-1:0] op, input logic [SYMBOL_BITS-1:0] sb,
                             input logic [INDEX_BITS-1:0] ix);
        while (idle_on && $urandom_range(99) < IDLE_PERCENT) begin
            cmd.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd.valid       <= 1'b1;
        cmd.operation   <= op;
        cmd.spec_byte   <= sb;
        cmd.entry_index <= ix;
        do @(posedge i_clk); while (!cmd.ready);
        lookup_sb.note_command(op, sb, ix);
        if (op != OP_UNUSED) begin
            words_sent++;
        end
    endtask

    task automatic send_lookup();
        logic [INDEX_BITS-1:0] ix;
        int unsigned           pick;
        pick = $urandom_range(99);
        if (pick < 55 && lookup_sb.longest != 0) begin
            ix = INDEX_BITS'($urandom_range(0, (1 << lookup_sb.longest) - 1));
        end else if (pick < 75) begin
            ix = lookup_sb.fill_point[INDEX_BITS-1:0] + INDEX_BITS'($urandom_range(0, 2))
                 - INDEX_BITS'(1);
        end else begin
            ix = rand_index();
        end
        send_word(OP_READ, rand_byte(), ix);
    endtask

    task automatic wait_for_lookups();
        cmd.valid <= 1'b0;
        do @(posedge i_clk); while (lookup_sb.pending_lookups.size() != 0);
    endtask

    initial begin
        forever begin
            t_lookup got;
            @(posedge i_clk);
            if (i_rst_n && rsp.valid && rsp.ready) begin
                got.entry_valid    = rsp.entry_valid;
                got.code_length    = rsp.code_length;
                got.symbol         = rsp.symbol;
                got.longest_length = rsp.longest_length;
                lookup_sb.check_lookup(got);
            end
            rsp.ready <= !(idle_on && $urandom_range(99) < IDLE_PERCENT);
        end
    end

    initial begin
        quiet_cycles = 0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n || (cmd.valid && cmd.ready) || (rsp.valid && rsp.ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("huffman_lookup_table_builder test failed");
                $finish;
            end
        end
    end

    initial begin
        int unsigned          sessions;
        int unsigned          big_tables;
        int unsigned          top;
        int unsigned          counted;
        int unsigned          n_symbols;
        logic [SYMBOL_BITS-1:0] counts [COUNT_BYTES];

        lookup_sb       = new();
        idle_on         = 1'b1;
        words_sent      = 0;
        i_rst_n         <= 1'b0;
        cmd.valid       <= 1'b0;
        cmd.operation   <= OP_RESTART;
        cmd.spec_byte   <= '0;
        cmd.entry_index <= '0;
        rsp.ready       <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // A reset table answers every read as invalid.
        send_word(OP_READ, 8'h00, 16'hFFFF);
        send_word(OP_UNUSED, 8'hA5, 16'h1234);
        send_word(OP_RESTART, 8'hFF, 16'h0000);
        // One code of length 1 and two of length 16: the first symbol covers
        // half the table, the next two take one entry each, a fourth is extra.
        for (int len = 1; len <= COUNT_BYTES; len++) begin
            send_word(OP_LOAD, (len == 1) ? 8'd1 : (len == COUNT_BYTES) ? 8'd2 : 8'd0,
                      16'h0000);
        end
        send_word(OP_LOAD, 8'h00, 16'hFFFF);
        send_word(OP_LOAD, 8'hFF, 16'h0000);
        send_word(OP_LOAD, 8'h5A, 16'h0000);
        send_word(OP_LOAD, 8'h3C, 16'h0000);
        send_word(OP_READ, 8'h00, 16'h0000);
        send_word(OP_READ, 8'h00, 16'h8001);
        send_word(OP_READ, 8'h00, 16'h8002);
        send_word(OP_READ, 8'h00, 16'hFFFF);
        wait_for_lookups();

        words_sent = 0;
        sessions   = 0;
        big_tables = 0;
        while (words_sent < RANDOM_WORDS) begin
            idle_on = !(sessions >= 20 && sessions < 30);
            if (sessions % 12 == 5 && big_tables < 3) begin
                top = $urandom_range(12, 16);
                big_tables++;
            end else if ($urandom_range(99) < 8) begin
                top = 0;
            end else begin
                top = $urandom_range(1, 8);
            end
            counted = 0;
            for (int len = 1; len <= COUNT_BYTES; len++) begin
                if (len > top) begin
                    counts[len-1] = '0;
                end else if (len == top) begin
                    counts[len-1] = SYMBOL_BITS'($urandom_range(1, 4));
                end else if ($urandom_range(99) < 5) begin
                    counts[len-1] = rand_byte();
                end else begin
                    counts[len-1] = ($urandom_range(99) < 50)
                                  ? '0 : SYMBOL_BITS'($urandom_range(1, 2));
                end
                counted += counts[len-1];
            end
            case ($urandom_range(9))
                0:       n_symbols = counted + $urandom_range(1, 4);
                1:       n_symbols = $urandom_range(0, counted);
                default: n_symbols = counted;
            endcase
            if (n_symbols > 48) begin
                n_symbols = 48;
            end

            if ($urandom_range(99) < 10) begin
                send_word(OP_RESTART, rand_byte(), rand_index());
                repeat ($urandom_range(1, 15)) begin
                    send_word(OP_LOAD, rand_byte(), rand_index());
                end
                send_lookup();
            end
            if ($urandom_range(99) < 90) begin
                send_word(OP_RESTART, rand_byte(), rand_index());
            end
            if ($urandom_range(99) < 10) begin
                send_word(OP_UNUSED, rand_byte(), rand_index());
            end
            for (int len = 1; len <= COUNT_BYTES; len++) begin
                send_word(OP_LOAD, counts[len-1], rand_index());
                if ($urandom_range(99) < 5) begin
                    send_lookup();
                end
            end
            for (int unsigned i = 0; i < n_symbols; i++) begin
                send_word(OP_LOAD, rand_byte(), rand_index());
                if ($urandom_range(99) < 25) begin
                    send_lookup();
                end
            end
            repeat ($urandom_range(8, 30)) begin
                send_lookup();
            end
            if (sessions % 7 == 3) begin
                wait_for_lookups();
            end
            sessions++;
        end

        wait_for_lookups();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (lookup_sb.mismatches == 0) begin
            $display("huffman_lookup_table_builder test passed");
        end else begin
            $display("huffman_lookup_table_builder test failed");
        end
        $finish;
    end

endmodule

### filelist.f
sv/hltb_pkg.sv
sv/hltb_if.sv
sv/huffman_lookup_table_builder.sv
test/hltb_lookup_check_pkg.sv
test/huffman_lookup_table_builder_test.sv
